// ===== src/rmt_pkg.sv =====
package rmt_pkg;

  // Widths and sizes
  localparam int unsigned PosW      = 16;
  localparam int unsigned MaxTok    = 5;
  localparam int unsigned TokCntW   = 3;
  localparam int unsigned SkipW     = 4;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned IntBytes  = 8;
  localparam int unsigned PingLen   = 7;
  localparam int unsigned OkLen     = 5;

  // Characters the lexer looks for
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [3:0] {
    TOK_EOF     = 4'd0,
    TOK_OK      = 4'd1,
    TOK_PING    = 4'd2,
    TOK_TYPE    = 4'd3,
    TOK_LEN     = 4'd4,
    TOK_CR      = 4'd5,
    TOK_LF      = 4'd6,
    TOK_BULK    = 4'd7,
    TOK_INT     = 4'd8,
    TOK_ILLEGAL = 4'd9
  } tok_kind_e;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_LEN   = 5'b00010,
    MODE_BULK  = 5'b00100,
    MODE_SKIP  = 5'b01000,
    MODE_MATCH = 5'b10000
  } run_mode_e;

  typedef struct packed {
    tok_kind_e        kind;
    logic [PosW-1:0]  offset;
    logic [7:0]       fbyte;
  } tok_t;

  typedef struct packed {
    logic [TokCntW-1:0]  count;
    tok_t [MaxTok-1:0]   toks;
  } tok_set_t;

  // Byte idx of the PING (target 0) or OK (target 1) message
  function automatic logic [7:0] pat_byte(logic target, logic [IdxW-1:0] idx);
    logic [7:0] r;
    r = ChNul;
    if (!target) begin
      unique case (idx)
        3'd0:    r = ChPlus;
        3'd1:    r = 8'h50;
        3'd2:    r = 8'h49;
        3'd3:    r = 8'h4E;
        3'd4:    r = 8'h47;
        3'd5:    r = ChCr;
        3'd6:    r = ChLf;
        default: r = ChNul;
      endcase
    end else begin
      unique case (idx)
        3'd0:    r = ChPlus;
        3'd1:    r = 8'h4F;
        3'd2:    r = 8'h4B;
        3'd3:    r = ChCr;
        3'd4:    r = ChLf;
        default: r = ChNul;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/rmt_lexer.sv =====
module rmt_lexer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      is_last_i,
  input  logic [15:0]               msg_len_i,
  output rmt_pkg::tok_set_t         set_o
);
  import rmt_pkg::*;

  typedef struct packed {
    logic                 emit;
    tok_t                 tok;
    run_mode_e            mode;
    logic [SkipW-1:0]     skip;
    logic                 mstart;
    logic                 mtgt;
  } lex_res_t;

  // Lex one ordinary byte against the current run mode
  function automatic lex_res_t lex_byte(run_mode_e mode, logic [SkipW-1:0] skip,
                                        logic [7:0] b, logic [PosW-1:0] pos,
                                        logic may_match, logic last,
                                        logic [15:0] mlen);
    lex_res_t r;
    logic     dispatch;
    logic     digit;
    digit         = (b >= ChZero) && (b <= ChNine);
    dispatch      = 1'b1;
    r.emit        = 1'b0;
    r.tok.kind    = TOK_EOF;
    r.tok.offset  = pos;
    r.tok.fbyte   = b;
    r.mode        = mode;
    r.skip        = skip;
    r.mstart      = 1'b0;
    r.mtgt        = 1'b0;
    unique case (mode)
      MODE_SKIP: begin
        dispatch = 1'b0;
        if (skip != '0) r.skip = skip - 1'b1;
        if (r.skip == '0) r.mode = MODE_IDLE;
      end
      MODE_BULK: if (b != ChCr) dispatch = 1'b0;
      MODE_LEN:  if (digit) dispatch = 1'b0;
      default: ;
    endcase
    if (dispatch) begin
      r.mode = MODE_IDLE;
      r.emit = 1'b1;
      priority if (b == ChStar || b == ChDollar) begin
        r.tok.kind = TOK_TYPE;
      end else if (b == ChColon) begin
        r.tok.kind = TOK_INT;
        r.skip     = SkipW'(IntBytes);
        r.mode     = MODE_SKIP;
      end else if (b == ChPlus) begin
        if (may_match && pos == '0 && !last &&
            (mlen == 16'(PingLen) || mlen == 16'(OkLen))) begin
          r.emit   = 1'b0;
          r.mode   = MODE_MATCH;
          r.mstart = 1'b1;
          r.mtgt   = (mlen == 16'(OkLen));
        end else begin
          r.tok.kind = TOK_ILLEGAL;
        end
      end else if (b == ChCr) begin
        r.tok.kind = TOK_CR;
      end else if (b == ChLf) begin
        r.tok.kind = TOK_LF;
      end else if (b == ChNul) begin
        r.tok.kind = TOK_EOF;
      end else if (digit) begin
        r.tok.kind = TOK_LEN;
        r.mode     = MODE_LEN;
      end else begin
        r.tok.kind = TOK_BULK;
        r.mode     = MODE_BULK;
      end
    end
    return r;
  endfunction

  logic [PosW-1:0]   pos_q, pos_d;
  run_mode_e         mode_q, mode_d;
  logic [SkipW-1:0]  skip_q, skip_d;
  logic [IdxW-1:0]   midx_q, midx_d;
  logic              mtgt_q, mtgt_d;

  logic              in_match, hit, done, fail, use_lex;
  logic [IdxW-1:0]   plen, idx;
  logic              rp_bulk, rp_cr;
  run_mode_e         rp_mode, lex_mode;
  lex_res_t          lr;
  logic [PosW-1:0]   pos_inc;
  logic [MaxTok-1:0] cand_v;
  tok_t [MaxTok-1:0] cand;
  tok_set_t          set;

  // Match tracking for the PING/OK whole-message patterns
  always_comb begin
    in_match = (mode_q == MODE_MATCH);
    plen     = mtgt_q ? IdxW'(OkLen) : IdxW'(PingLen);
    idx      = (midx_q >= plen) ? plen - 1'b1 : midx_q;
    hit      = (data_byte_i == pat_byte(mtgt_q, idx)) &&
               !(is_last_i && ({1'b0, idx} + 4'd1 < {1'b0, plen}));
    done     = in_match && hit && ({1'b0, idx} + 4'd1 == {1'b0, plen});
    fail     = in_match && !hit;
    use_lex  = !in_match || fail;
    // held bytes replay as one bulk run that a CR may close
    rp_bulk  = (idx >= 3'd2);
    rp_cr    = (idx == plen - 1'b1);
    rp_mode  = (rp_bulk && !rp_cr) ? MODE_BULK : MODE_IDLE;
    lex_mode = fail ? rp_mode : mode_q;
    lr       = lex_byte(lex_mode, skip_q, data_byte_i, pos_q, !fail, is_last_i, msg_len_i);
  end

  // Next state and candidate tokens
  always_comb begin
    pos_inc = pos_q + 1'b1;
    mode_d  = mode_q;
    skip_d  = skip_q;
    midx_d  = midx_q;
    mtgt_d  = mtgt_q;
    if (in_match) begin
      if (fail) begin
        mode_d = lr.mode;
        skip_d = lr.skip;
        midx_d = '0;
      end else if (done) begin
        mode_d = MODE_IDLE;
        midx_d = '0;
      end else begin
        midx_d = idx + 1'b1;
      end
    end else begin
      mode_d = lr.mode;
      skip_d = lr.skip;
      if (lr.mstart) begin
        midx_d = IdxW'(1);
        mtgt_d = lr.mtgt;
      end
    end

    cand_v[0]       = done || fail;
    cand[0].kind    = done ? (mtgt_q ? TOK_OK : TOK_PING) : TOK_ILLEGAL;
    cand[0].offset  = '0;
    cand[0].fbyte   = ChPlus;
    cand_v[1]       = fail && rp_bulk;
    cand[1].kind    = TOK_BULK;
    cand[1].offset  = PosW'(1);
    cand[1].fbyte   = pat_byte(mtgt_q, IdxW'(1));
    cand_v[2]       = fail && rp_cr;
    cand[2].kind    = TOK_CR;
    cand[2].offset  = PosW'(plen - 3'd2);
    cand[2].fbyte   = ChCr;
    cand_v[3]       = use_lex && lr.emit;
    cand[3]         = lr.tok;
    cand_v[4]       = is_last_i;
    cand[4].kind    = TOK_EOF;
    cand[4].offset  = pos_inc + ((mode_d == MODE_SKIP) ? PosW'(skip_d) : '0);
    cand[4].fbyte   = ChNul;

    pos_d = pos_inc;
    if (is_last_i) begin
      pos_d  = '0;
      mode_d = MODE_IDLE;
      skip_d = '0;
      midx_d = '0;
      mtgt_d = 1'b0;
    end
  end

  // Pack the valid candidates in order
  always_comb begin
    set = '0;
    for (int i = 0; i < MaxTok; i++) begin
      if (cand_v[i]) begin
        set.toks[set.count] = cand[i];
        set.count           = set.count + 1'b1;
      end
    end
  end

  assign set_o = set;

  // Advance lexer state when the byte is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mode_q <= MODE_IDLE;
      skip_q <= '0;
      midx_q <= '0;
      mtgt_q <= 1'b0;
    end else if (take_i) begin
      pos_q  <= pos_d;
      mode_q <= mode_d;
      skip_q <= skip_d;
      midx_q <= midx_d;
      mtgt_q <= mtgt_d;
    end
  end

endmodule

// ===== src/rmt_tok_buf.sv =====
module rmt_tok_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  rmt_pkg::tok_set_t   set_i,
  input  logic                out_ready_i,
  output logic                free_o,
  output logic                out_valid_o,
  output rmt_pkg::tok_t       tok_o,
  output logic                run_end_o
);
  import rmt_pkg::*;

  logic [TokCntW-1:0]  cnt_q;
  tok_t [MaxTok-1:0]   toks_q;
  logic [MaxTok-1:0]   end_q;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign tok_o       = toks_q[0];
  assign run_end_o   = end_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == '0) || (cnt_q == TokCntW'(1) && pop);

  // Hold the count; load a new set or drop the word just taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= set_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Token words shift toward the head
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      toks_q <= set_i.toks;
      for (int i = 0; i < MaxTok; i++) begin
        end_q[i] <= (TokCntW'(i) == set_i.count - 1'b1);
      end
    end else if (pop) begin
      for (int i = 0; i < MaxTok - 1; i++) begin
        toks_q[i] <= toks_q[i+1];
        end_q[i]  <= end_q[i+1];
      end
    end
  end

endmodule

// ===== src/resp_message_tokenizer_core.sv =====
// RESP message tokenizer. Message bytes enter on the in_* channel, one word per
// byte with is_last_i on the final byte; tokens leave on the out_* channel with
// kind, start offset and first byte, run_end_o marking the last token that a
// byte caused. Write message_length through cfg_we_i/cfg_wdata_i before a
// message that may be "+PING\r\n" or "+OK\r\n". A byte waits in the input
// register, where the lexer turns it into zero to five tokens that load into
// a five-entry token buffer. The buffer drains one token per cycle while
// out_ready_i is high. A byte with tokens holds the input register until the
// buffer is free; bytes with at most one token, nearly all of them, go at one
// per cycle unless out_ready_i stalls.
module resp_message_tokenizer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [7:0]   data_byte_i,
  input  logic         is_last_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [3:0]   token_kind_o,
  output logic [15:0]  start_offset_o,
  output logic [7:0]   first_byte_o,
  output logic         run_end_o
);
  import rmt_pkg::*;

  logic        in_valid_q;
  logic [7:0]  data_q;
  logic        last_q;
  logic [15:0] mlen_q;
  logic        take, buf_free, load;
  tok_set_t    set;
  tok_t        tok;

  assign take       = in_valid_q && ((set.count == '0) || buf_free);
  assign load       = take && (set.count != '0);
  assign in_ready_o = !in_valid_q || take;

  // Message length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mlen_q <= '0;
    end else if (cfg_we_i) begin
      mlen_q <= cfg_wdata_i;
    end
  end

  // Input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_byte_i;
      last_q <= is_last_i;
    end
  end

  rmt_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (data_q),
    .is_last_i   (last_q),
    .msg_len_i   (mlen_q),
    .set_o       (set)
  );

  rmt_tok_buf u_tok_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .set_i       (set),
    .out_ready_i (out_ready_i),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .tok_o       (tok),
    .run_end_o   (run_end_o)
  );

  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.offset;
  assign first_byte_o   = tok.fbyte;

endmodule

// ===== dv/tb_resp_message_tokenizer_core.sv =====
`timescale 1ns / 100ps

module tb_resp_message_tokenizer_core;
  import rmt_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned PhaseWords = 26;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    tok_kind_e       kind;
    logic [PosW-1:0] offset;
    logic [7:0]      fbyte;
    logic            run_end;
  } exp_tok_t;

  // Lexer state mirror and the tokens still owed by the block
  class token_tracker;
    logic [15:0]      msg_len;
    logic [PosW-1:0]  pos;
    run_mode_e        mode;
    logic [SkipW-1:0] skip;
    logic [IdxW-1:0]  midx;
    logic             mtarget;
    exp_tok_t         step_toks[$];
    exp_tok_t         tokens_due[$];
    int               errors;

    function new();
      msg_len = '0;
      pos     = '0;
      mode    = MODE_IDLE;
      skip    = '0;
      midx    = '0;
      mtarget = 1'b0;
      errors  = 0;
    endfunction

    task report(string what);
      errors++;
      // keep the log short on a mismatch storm
      if (errors <= 50) begin
        $display("ERROR: %s", what);
      end
    endtask

    // Byte idx of the whole-message pattern: PING for target 0, OK for target 1
    function logic [7:0] match_char(logic tgt, int idx);
      string s;
      s = tgt ? "+OK\015\012" : "+PING\015\012";
      return s[idx];
    endfunction

    function bit digit(logic [7:0] d);
      return d >= ChZero && d <= ChNine;
    endfunction

    // Hold at most MaxTok tokens per word; extra ones are dropped
    function void emit_tok(tok_kind_e k, logic [PosW-1:0] off, logic [7:0] fb);
      if (step_toks.size() < MaxTok) begin
        step_toks.push_back('{kind: k, offset: off, fbyte: fb, run_end: 1'b0});
      end
    endfunction

    // Lex one ordinary byte; a '+' at offset 0 may open a match if allowed
    function void lex_char(logic [7:0] d, logic [PosW-1:0] p, bit may_match, bit fin);
      if (mode == MODE_SKIP) begin
        if (skip != 0) skip--;
        if (skip == 0) mode = MODE_IDLE;
        return;
      end
      if (mode == MODE_BULK) begin
        if (d != ChCr) return;
        mode = MODE_IDLE;
      end
      if (mode == MODE_LEN) begin
        if (digit(d)) return;
        mode = MODE_IDLE;
      end
      case (d)
        ChStar, ChDollar: emit_tok(TOK_TYPE, p, d);
        ChColon: begin
          emit_tok(TOK_INT, p, d);
          skip = SkipW'(IntBytes);
          mode = (skip != 0) ? MODE_SKIP : MODE_IDLE;
        end
        ChPlus: begin
          if (may_match && p == 0 && !fin && (msg_len == PingLen || msg_len == OkLen)) begin
            mtarget = (msg_len == OkLen);
            midx    = IdxW'(1);
            mode    = MODE_MATCH;
          end else begin
            emit_tok(TOK_ILLEGAL, p, d);
          end
        end
        ChCr:  emit_tok(TOK_CR, p, d);
        ChLf:  emit_tok(TOK_LF, p, d);
        ChNul: emit_tok(TOK_EOF, p, ChNul);
        default: begin
          if (digit(d)) begin
            emit_tok(TOK_LEN, p, d);
            mode = MODE_LEN;
          end else begin
            emit_tok(TOK_BULK, p, d);
            mode = MODE_BULK;
          end
        end
      endcase
    endfunction

    // Work out the tokens of one accepted word and queue them
    function void note_byte(logic [7:0] d, logic fin);
      logic [PosW-1:0] p;
      logic [PosW-1:0] off;
      int idx;
      int plen;
      step_toks.delete();
      p = pos;
      if (mode == MODE_MATCH) begin
        plen = mtarget ? OkLen : PingLen;
        idx  = midx;
        if (idx >= plen) idx = plen - 1;
        if (d == match_char(mtarget, idx) && !(fin && idx + 1 < plen)) begin
          if (idx + 1 == plen) begin
            emit_tok(mtarget ? TOK_OK : TOK_PING, '0, ChPlus);
            mode = MODE_IDLE;
            midx = '0;
          end else begin
            midx = IdxW'(idx + 1);
          end
        end else begin
          // drop the match and replay the held bytes from offset 1
          emit_tok(TOK_ILLEGAL, '0, ChPlus);
          mode = MODE_IDLE;
          midx = '0;
          for (int k = 1; k < idx; k++) begin
            lex_char(match_char(mtarget, k), PosW'(k), 1'b0, 1'b0);
          end
          lex_char(d, p, 1'b0, fin);
        end
      end else begin
        lex_char(d, p, 1'b1, fin);
      end
      pos = p + 1'b1;
      if (fin) begin
        off = pos;
        if (mode == MODE_SKIP) off = off + PosW'(skip);
        emit_tok(TOK_EOF, off, ChNul);
        pos     = '0;
        mode    = MODE_IDLE;
        skip    = '0;
        midx    = '0;
        mtarget = 1'b0;
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].run_end = 1'b1;
      foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
    endfunction

    // Compare one delivered token with the oldest one due
    task check_token(logic [3:0] kind, logic [PosW-1:0] off, logic [7:0] fb, logic re);
      exp_tok_t e;
      if (tokens_due.size() == 0) begin
        report($sformatf("token with nothing due: kind %0d off %0d byte %h end %b",
                         kind, off, fb, re));
        return;
      end
      e = tokens_due.pop_front();
      if (kind !== e.kind || off !== e.offset || fb !== e.fbyte || re !== e.run_end) begin
        report($sformatf("token kind %0d off %0d byte %h end %b, want %0d %0d %h %b",
                         kind, off, fb, re, e.kind, e.offset, e.fbyte, e.run_end));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        is_last_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  token_kind_o;
  logic [15:0] start_offset_o;
  logic [7:0]  first_byte_o;
  logic        run_end_o;

  token_tracker sb;
  int unsigned  cycles     = 0;
  int unsigned  burst_left = 0;
  logic [15:0]  stall_pat  = 16'hFFFF;

  resp_message_tokenizer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .first_byte_o   (first_byte_o),
    .run_end_o      (run_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles and stall the token side on a random pattern redrawn from time to time
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles[5:0] == 0) begin
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    out_ready_i <= stall_pat[cycles[3:0]];
  end

  // Check every token word taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_token(token_kind_o, start_offset_o, first_byte_o, run_end_o);
    end
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Bytes the lexer treats specially, mixed with plain random ones
  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 5))
      0:       return ChNul;
      1:       return ChCr;
      2:       return ChLf;
      3:       return ChPlus;
      4:       return ChColon;
      default: return 8'($urandom);
    endcase
  endfunction

  // Build one message: mostly well formed, some broken, some noise
  function automatic byte_q_t next_message();
    byte_q_t m;
    string   pat;
    int      n;
    int      len;
    int      cut;
    pat = ($urandom_range(0, 1) == 0) ? "+PING\015\012" : "+OK\015\012";
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom_range(1, 2);
        m = text_bytes($sformatf("*%0d\015\012", n));
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            m.push_back(ChColon);
            repeat (IntBytes) m.push_back(odd_byte());
          end else begin
            len = $urandom_range(0, 4);
            m = {m, text_bytes($sformatf("$%0d\015\012", len))};
            repeat (len) m.push_back(8'($urandom_range(8'h61, 8'h7A)));
          end
          m = {m, text_bytes("\015\012")};
        end
      end
      2, 3: m = text_bytes(pat);
      4: begin
        // cut the match short or corrupt one byte of it
        m   = text_bytes(pat);
        cut = $urandom_range(1, pat.len() - 1);
        if ($urandom_range(0, 1) == 0) begin
          m = m[0:cut-1];
        end else begin
          m[cut] = odd_byte();
        end
      end
      5: begin
        m.push_back(ChColon);
        repeat ($urandom_range(0, IntBytes + 2)) m.push_back(odd_byte());
      end
      6: begin
        repeat ($urandom_range(1, 6)) m.push_back(8'($urandom_range(8'h20, 8'h7E)));
        if ($urandom_range(0, 1) == 0) m = {m, text_bytes("\015\012")};
      end
      7, 8: begin
        repeat ($urandom_range(1, 6)) m.push_back(($urandom_range(0, 3) == 0) ?
                                                  odd_byte() : 8'($urandom));
      end
      default: m = text_bytes($sformatf("$%0d\015\012", $urandom_range(0, 99999)));
    endcase
    return m;
  endfunction

  // Offer one word, idling between bursts, and hold it until taken
  task automatic send_word(logic [7:0] d, logic fin);
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    is_last_i   <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(d, fin);
  endtask

  task automatic send_message(byte_q_t m);
    foreach (m[i]) send_word(m[i], i == m.size() - 1);
  endtask

  // Drop valid, wait for every token due, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.tokens_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_length(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.msg_len = v;
  endtask

  initial begin
    byte_q_t     m;
    int          sent;
    logic [15:0] lens[5];
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every token kind, zero byte, digit run, bulk to CR, stray '+', INT at end
    write_length(16'd0);
    m = text_bytes("*$");
    m.push_back(ChNul);
    m = {m, text_bytes("97\015\012")};
    m.push_back(8'hFF);
    m = {m, text_bytes("\015+:")};
    send_message(m);
    settle();
    write_length(16'(PingLen));
    send_message(text_bytes("+PING\015\012"));
    settle();
    write_length(16'(OkLen));
    send_message(text_bytes("+OK\015\012"));
    settle();

    // Random messages under several lengths
    lens = '{16'(PingLen), 16'(OkLen), 16'd0, 16'hFFFF, 16'($urandom)};
    foreach (lens[p]) begin
      write_length(lens[p]);
      sent = 0;
      while (sent < PhaseWords) begin
        m = next_message();
        send_message(m);
        sent += m.size();
      end
      settle();
    end

    if (sb.tokens_due.size() != 0) begin
      sb.report($sformatf("%0d tokens never arrived", sb.tokens_due.size()));
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
